>>> rtl/cmp_pkg.sv
package cmp_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 16;

    // Full pipeline depth from the input register to the result register.
    localparam int LATENCY  = CORDIC_STEPS + 2;
    // Extra delay after the root so both paths line up.
    localparam int SQRT_PAD = LATENCY - SQRT_STEPS - 3;

    localparam int XY_W   = 35;
    localparam int Z_W    = 34;
    localparam int RAD_W  = 2 * SAMPLE_W;
    localparam int REM_W  = SAMPLE_W + 2;

    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_MAGNITUDE_ENABLE = 2'd0;
    localparam cfg_index_t REG_PHASE_ENABLE     = 2'd1;

    localparam logic [SAMPLE_W-1:0] PHASE_ZERO          = 16'h0000;
    localparam logic [SAMPLE_W-1:0] PHASE_PI            = 16'h8000;
    localparam logic [SAMPLE_W-1:0] PHASE_HALF_PI       = 16'h4000;
    localparam logic [SAMPLE_W-1:0] PHASE_MINUS_HALF_PI = 16'hC000;

    // Angle accumulator scale: 2^31 stands for pi.
    localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(1) << 30;
    localparam logic signed [Z_W-1:0] Z_ROUND   = Z_W'(1) << 15;

    localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic advance;
        logic magnitude_enable;
        logic phase_enable;
    } pipe_ctrl_t;

endpackage

>>> rtl/cmp_sqrt_pipe.sv
module cmp_sqrt_pipe
(
    input  logic                                clk,
    input  cmp_pkg::pipe_ctrl_t                 ctrl,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] real_part,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] imag_part,
    output logic        [cmp_pkg::SAMPLE_W-1:0] magnitude
);

    localparam int SW = cmp_pkg::SAMPLE_W;
    localparam int RW = cmp_pkg::RAD_W;
    localparam int MW = cmp_pkg::REM_W;
    localparam int NS = cmp_pkg::SQRT_STEPS;
    localparam int NP = cmp_pkg::SQRT_PAD;

    logic signed [RW-1:0] prod_re;
    logic signed [RW-1:0] prod_im;
    logic [RW-1:0] sq_re_reg;
    logic [RW-1:0] sq_im_reg;
    logic [RW-1:0] sum_reg;

    logic [RW-1:0] rad_reg  [NS];
    logic [MW-1:0] rem_reg  [NS];
    logic [SW-1:0] root_reg [NS];

    logic [SW-1:0] round_reg;
    logic [SW-1:0] pad_reg [NP];

    assign prod_re = real_part * real_part;
    assign prod_im = imag_part * imag_part;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            sq_re_reg <= unsigned'(prod_re);
            sq_im_reg <= unsigned'(prod_im);
            sum_reg   <= sq_re_reg + sq_im_reg;
        end
    end

    // One root bit per stage, restoring form.
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic [RW-1:0] rad_in;
        logic [MW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [MW+1:0] cur;
        logic [MW+1:0] sub;
        logic [MW+1:0] diff;
        logic          fits;

        if (k == 0)
        begin : g_first
            assign rad_in  = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign cur  = {rem_in, rad_in[RW-1:RW-2]};
        assign sub  = {2'b00, root_in, 2'b01};
        assign diff = cur - sub;
        assign fits = (cur >= sub);

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= fits ? diff[MW-1:0] : cur[MW-1:0];
                root_reg[k] <= {root_in[SW-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            if (!ctrl.magnitude_enable)
                round_reg <= '0;
            else if (rem_reg[NS-1] > {2'b00, root_reg[NS-1]})
                round_reg <= root_reg[NS-1] + SW'(1);
            else
                round_reg <= root_reg[NS-1];

            pad_reg[0] <= round_reg;
            for (int k = 1; k < NP; k++)
                pad_reg[k] <= pad_reg[k-1];
        end
    end

    assign magnitude = pad_reg[NP-1];

endmodule

>>> rtl/cmp_cordic_pipe.sv
module cmp_cordic_pipe
(
    input  logic                                clk,
    input  cmp_pkg::pipe_ctrl_t                 ctrl,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] real_part,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] imag_part,
    output logic signed [cmp_pkg::SAMPLE_W-1:0] phase_angle
);

    localparam int SW = cmp_pkg::SAMPLE_W;
    localparam int XW = cmp_pkg::XY_W;
    localparam int ZW = cmp_pkg::Z_W;
    localparam int NS = cmp_pkg::CORDIC_STEPS;

    logic signed [XW-1:0] re_ext;
    logic signed [XW-1:0] im_ext;
    logic signed [XW-1:0] x_pre;
    logic signed [XW-1:0] y_pre;
    logic signed [ZW-1:0] z_pre;
    logic                 special_pre;
    logic [1:0]           axis_pre;

    logic signed [XW-1:0] x_reg [NS+1];
    logic signed [XW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0] z_reg [NS+1];
    logic                 special_reg [NS+1];
    logic [1:0]           axis_reg [NS+1];

    logic signed [ZW-1:0] z_round;
    logic [SW-1:0]        phase_reg;

    assign re_ext = {{(XW-2*SW){real_part[SW-1]}}, real_part, SW'(0)};
    assign im_ext = {{(XW-2*SW){imag_part[SW-1]}}, imag_part, SW'(0)};

    // Fold the left half plane into the right one.
    always_comb
    begin
        x_pre = re_ext;
        y_pre = im_ext;
        z_pre = '0;
        if (real_part[SW-1])
        begin
            if (!imag_part[SW-1])
            begin
                x_pre = im_ext;
                y_pre = -re_ext;
                z_pre = cmp_pkg::Z_HALF_PI;
            end
            else
            begin
                x_pre = -im_ext;
                y_pre = re_ext;
                z_pre = -cmp_pkg::Z_HALF_PI;
            end
        end
    end

    // Samples on an axis bypass the iteration; only the top two bits differ.
    always_comb
    begin
        special_pre = (imag_part == '0) || (real_part == '0);
        if (imag_part == '0)
            axis_pre = real_part[SW-1] ? cmp_pkg::PHASE_PI[SW-1:SW-2]
                                       : cmp_pkg::PHASE_ZERO[SW-1:SW-2];
        else
            axis_pre = imag_part[SW-1] ? cmp_pkg::PHASE_MINUS_HALF_PI[SW-1:SW-2]
                                       : cmp_pkg::PHASE_HALF_PI[SW-1:SW-2];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            x_reg[0]       <= x_pre;
            y_reg[0]       <= y_pre;
            z_reg[0]       <= z_pre;
            special_reg[0] <= special_pre;
            axis_reg[0]    <= axis_pre;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] angle;
        logic                 y_pos;

        assign dx    = y_reg[k] >>> k;
        assign dy    = x_reg[k] >>> k;
        assign angle = signed'({2'b00, cmp_pkg::ATAN_TABLE[k]});
        assign y_pos = !y_reg[k][XW-1] && (y_reg[k] != '0);

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                if (y_pos)
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + angle;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - angle;
                end
                special_reg[k+1] <= special_reg[k];
                axis_reg[k+1]    <= axis_reg[k];
            end
        end
    end

    assign z_round = z_reg[NS] + cmp_pkg::Z_ROUND;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            if (!ctrl.phase_enable)
                phase_reg <= '0;
            else if (special_reg[NS])
                phase_reg <= {axis_reg[NS], (SW-2)'(0)};
            else
                phase_reg <= z_round[2*SW-1:SW];
        end
    end

    assign phase_angle = signed'(phase_reg);

endmodule

>>> rtl/complex_magnitude_phase_top.sv
// Magnitude and phase of a complex sample stream.
// Accepted input words flow through the datapath stages to result words; an
// output stall holds the pipeline. Throughput: one word per cycle unless stalled.
// Reset (rst_n low, asynchronous): pipeline and skid empty, magnitude output
// enabled, phase output disabled. Payload registers are not reset.
module complex_magnitude_phase_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] real_part,
    input  logic signed [cmp_pkg::SAMPLE_W-1:0] imag_part,
    input  logic                                frame_end,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [cmp_pkg::SAMPLE_W-1:0] magnitude,
    output logic signed [cmp_pkg::SAMPLE_W-1:0] phase_angle,
    output logic                                frame_end_out,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  cmp_pkg::cfg_index_t                 cfg_index,
    input  logic                                cfg_data
);

    localparam int SW  = cmp_pkg::SAMPLE_W;
    localparam int LAT = cmp_pkg::LATENCY;

    // Configuration registers.
    logic magnitude_enable_reg;
    logic phase_enable_reg;

    // Valid and frame-end marks ride alongside the datapath stages.
    logic valid_reg [LAT];
    logic fe_reg    [LAT];

    // Skid word: catches the last stage when the output stalls, so the
    // input side sees a registered stall and never a path from out_stall.
    logic                 skid_valid_reg;
    logic [SW-1:0]        skid_mag_reg;
    logic signed [SW-1:0] skid_phase_reg;
    logic                 skid_fe_reg;

    cmp_pkg::pipe_ctrl_t  ctrl;
    logic [SW-1:0]        pipe_mag;
    logic signed [SW-1:0] pipe_phase;
    logic                 pipe_valid;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_enable_reg <= 1'b1;
            phase_enable_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmp_pkg::REG_MAGNITUDE_ENABLE: magnitude_enable_reg <= cfg_data;
                cmp_pkg::REG_PHASE_ENABLE:     phase_enable_reg     <= cfg_data;
                default:                       ; // drop writes to unmapped indexes
            endcase
        end
    end

    // Advance the whole pipeline whenever the skid word is free.
    assign ctrl.advance          = !skid_valid_reg;
    assign ctrl.magnitude_enable = magnitude_enable_reg;
    assign ctrl.phase_enable     = phase_enable_reg;

    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            fe_reg[0] <= frame_end;
            for (int k = 1; k < LAT; k++)
                fe_reg[k] <= fe_reg[k-1];
        end
    end

    cmp_sqrt_pipe u_sqrt
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .real_part (real_part),
        .imag_part (imag_part),
        .magnitude (pipe_mag)
    );

    cmp_cordic_pipe u_cordic
    (
        .clk         (clk),
        .ctrl        (ctrl),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .phase_angle (pipe_phase)
    );

    assign pipe_valid = valid_reg[LAT-1];

    // Capture the last stage when it is offered and stalled; release on take.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (skid_valid_reg)
            skid_valid_reg <= out_stall;
        else
            skid_valid_reg <= pipe_valid && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_mag_reg   <= pipe_mag;
            skid_phase_reg <= pipe_phase;
            skid_fe_reg    <= fe_reg[LAT-1];
        end
    end

    assign out_valid     = skid_valid_reg || pipe_valid;
    assign magnitude     = skid_valid_reg ? skid_mag_reg   : pipe_mag;
    assign phase_angle   = skid_valid_reg ? skid_phase_reg : pipe_phase;
    assign frame_end_out = skid_valid_reg ? skid_fe_reg    : fe_reg[LAT-1];

endmodule

>>> rtl/cmp_checker.sv
module cmp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic        [cmp_pkg::SAMPLE_W-1:0] magnitude,
    input logic signed [cmp_pkg::SAMPLE_W-1:0] phase_angle,
    input logic                                frame_end_out
);

    // Hold a stalled result word steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(magnitude)
            && $stable(phase_angle) && $stable(frame_end_out))
        else $error("stalled output word changed");

    // Push back on the input only after the output stalled a word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without an output stall");

    // A held-back input means a word is waiting at the output.
    a_stall_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output word waiting");

    // Drop output valid only after a word was taken.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("output word vanished while stalled");

endmodule

bind complex_magnitude_phase_top cmp_checker u_checker (.*);

>>> verif/complex_magnitude_phase_top_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] phase;
    logic               frame_end;
} polar_word_t;

class polar_scoreboard;
    polar_word_t expected_q[$];
    logic        mag_on = 1'b1;
    logic        ph_on  = 1'b0;
    int          errors = 0;
    // atan(2^-i), with 2^31 standing for pi
    longint      atan_z[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    function void set_flag(cmp_pkg::cfg_index_t idx, logic value);
        if (idx == cmp_pkg::REG_MAGNITUDE_ENABLE)
            mag_on = value;
        else if (idx == cmp_pkg::REG_PHASE_ENABLE)
            ph_on = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Round half up: n + 1 when the remainder exceeds n.
    function logic [15:0] root_rounded(longint sum_sq);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= sum_sq)
                lo = mid;
            else
                hi = mid;
        end
        if (sum_sq - lo * lo > lo)
            lo++;
        return lo[15:0];
    endfunction

    function logic signed [15:0] angle_of(longint re, longint im);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        if (im == 0)
            return (re < 0) ? cmp_pkg::PHASE_PI : cmp_pkg::PHASE_ZERO;
        if (re == 0)
            return (im > 0) ? cmp_pkg::PHASE_HALF_PI : cmp_pkg::PHASE_MINUS_HALF_PI;
        x = re * 65536;
        y = im * 65536;
        z = 0;
        // fold the left half plane into the right one
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 1073741824;
            end
            else
            begin
                x = -y;
                y = t;
                z = -1073741824;
            end
        end
        for (int k = 0; k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_z[k];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_z[k];
            end
        end
        z = (z + 32768) >>> 16;
        return z[15:0];
    endfunction

    function void note_sample(logic signed [15:0] re, logic signed [15:0] im, logic fe);
        polar_word_t w;
        longint      re_l;
        longint      im_l;
        re_l = re;
        im_l = im;
        w.magnitude = mag_on ? root_rounded(re_l * re_l + im_l * im_l) : 16'd0;
        w.phase     = ph_on ? angle_of(re_l, im_l) : 16'sd0;
        w.frame_end = fe;
        expected_q.push_back(w);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [15:0] mag, logic signed [15:0] ph, logic fe);
        polar_word_t w;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected word mag=%0d phase=%0d fe=%0b", mag, ph, fe));
            return;
        end
        w = expected_q.pop_front();
        if (mag !== w.magnitude)
            report($sformatf("magnitude got %0d want %0d", mag, w.magnitude));
        if (ph !== w.phase)
            report($sformatf("phase_angle got %0d want %0d", ph, w.phase));
        if (fe !== w.frame_end)
            report($sformatf("frame_end_out got %0b want %0b", fe, w.frame_end));
    endtask
endclass

module complex_magnitude_phase_top_tb;

    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 6;
    // Indexes past the two flags; writes there must leave the flags alone.
    localparam cmp_pkg::cfg_index_t REG_SPARE_LO = 2'd2;
    localparam cmp_pkg::cfg_index_t REG_SPARE_HI = 2'd3;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic signed [15:0]  real_part     = '0;
    logic signed [15:0]  imag_part     = '0;
    logic                frame_end     = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic        [15:0]  magnitude;
    logic signed [15:0]  phase_angle;
    logic                frame_end_out;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    cmp_pkg::cfg_index_t cfg_index     = '0;
    logic                cfg_data      = 1'b0;

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    // Long output hold-off: armed once, counted up in the stall process.
    logic hold_arm   = 1'b0;
    int   hold_count = 0;

    polar_scoreboard sb = new();

    // Random phases: word count, flag settings and idling and stalling mix.
    int   phase_items[NUM_PHASES] = '{300, 300, 300, 300, 250, 300};
    logic phase_mag[NUM_PHASES]   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic phase_ph[NUM_PHASES]    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    int   phase_idle[NUM_PHASES]  = '{0, 52, 0, 8, 52, 0};
    int   phase_stall[NUM_PHASES] = '{0, 0, 52, 8, 52, 0};

    complex_magnitude_phase_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .real_part     (real_part),
        .imag_part     (imag_part),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .magnitude     (magnitude),
        .phase_angle   (phase_angle),
        .frame_end_out (frame_end_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Receiver: hold off for HOLD_CYCLES once armed, else stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_arm && hold_count < HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Predict on every accepted input word; values are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_sample(real_part, imag_part, frame_end);
    end

    // Check every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(magnitude, phase_angle, frame_end_out);
    end

    // Offer one sample; idle first at random, then hold it until accepted.
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic fe);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        real_part <= re;
        imag_part <= im;
        frame_end <= fe;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait for every predicted word, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (cmp_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // Write both flags in one burst with valid held high; the spare indexes
    // get the opposite values and must have no effect.
    task automatic program_flags(input logic mag_en, input logic ph_en);
        cmp_pkg::cfg_index_t idx_seq[4];
        logic                val_seq[4];
        idx_seq = '{REG_SPARE_LO, cmp_pkg::REG_MAGNITUDE_ENABLE,
                    cmp_pkg::REG_PHASE_ENABLE, REG_SPARE_HI};
        val_seq = '{~mag_en, mag_en, ph_en, ~ph_en};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_seq[k];
            cfg_data  <= val_seq[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_flag(idx_seq[k], val_seq[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random sample with a bias toward axes, extremes, diagonals and tiny values.
    task automatic pick_sample(output logic signed [15:0] re, output logic signed [15:0] im);
        int edge_vals[6];
        edge_vals = '{-32768, -32767, -1, 0, 1, 32767};
        re = 16'($urandom);
        im = 16'($urandom);
        case ($urandom_range(9))
            4:
            begin
                re = 16'(int'($urandom_range(16)) - 8);
                im = 16'(int'($urandom_range(16)) - 8);
            end
            5:
            begin
                if ($urandom_range(1))
                    im = '0;
                else
                    re = '0;
            end
            6:
            begin
                re = 16'(edge_vals[$urandom_range(5)]);
                im = 16'(edge_vals[$urandom_range(5)]);
            end
            7:
            begin
                im = $urandom_range(1) ? re : -re;
                im = im + 16'(int'($urandom_range(4)) - 2);
            end
            default: ;
        endcase
    endtask

    initial
    begin
        logic signed [15:0] re_v;
        logic signed [15:0] im_v;
        logic signed [15:0] dir_re[18];
        logic signed [15:0] dir_im[18];

        dir_re = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767,
                   1, -1, -1, 1, 3, -5, -32768, -32768, 1};
        dir_im = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768,
                   1, -1, 1, -1, 4, 12, 1, -1, -32768};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset flags: magnitude on, phase reads zero.
        send_sample(16'sd3, 16'sd4, 1'b1);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b0);
        drain_results();

        // Directed corners with both outputs on: zero, axes, full scale,
        // quadrant diagonals and the pi wrap.
        program_flags(1'b1, 1'b1);
        for (int k = 0; k < 18; k++)
            send_sample(dir_re[k], dir_im[k], k[0]);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_flags(phase_mag[p], phase_ph[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            // Hold the output off for a long stretch so the pipe backs up.
            if (p == 2)
                hold_arm <= 1'b1;
            for (int n = 0; n < phase_items[p]; n++)
            begin
                pick_sample(re_v, im_v);
                send_sample(re_v, im_v, $urandom_range(7) == 0);
            end
            drain_results();
        end

        if (sb.errors == 0)
            $display("complex_magnitude_phase_top_tb passed");
        else
            $display("complex_magnitude_phase_top_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("complex_magnitude_phase_top_tb failed");
        $finish;
    end

endmodule
